### rtl/fbl_pkg.sv
// ----------------------------------------------------------------------------
// fbl_pkg: shared types and constants of the board loader
// Item and result structs, request and status codes, character constants,
// and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package fbl_pkg;

    // Width used to compare the 4-bit register and request fields against
    // board sizes of up to sixteen.
    localparam int CMP_W = 6;

    localparam logic [7:0] CH_BLANK = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [1:0] KIND_BEGIN = 2'd0;
    localparam logic [1:0] KIND_BYTE  = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    localparam logic [1:0] STAT_OK         = 2'd0;
    localparam logic [1:0] STAT_LOADED     = 2'd1;
    localparam logic [1:0] STAT_FORMAT_ERR = 2'd2;
    localparam logic [1:0] STAT_BAD_REQ    = 2'd3;

    localparam logic CFG_RANK_COUNT   = 1'b0;
    localparam logic CFG_COLUMN_COUNT = 1'b1;

    localparam logic [3:0] RANK_COUNT_RESET   = 4'd8;
    localparam logic [3:0] COLUMN_COUNT_RESET = 4'd8;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] fen_byte;
        logic [3:0] read_column;
        logic [3:0] read_rank;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] cell_value;
    } t_out_item;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_FILL,
        PH_SEP
    } t_phase;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_EXEC,
        CS_DRAIN,
        CS_READ,
        CS_DONE
    } t_ctl_state;

    typedef struct packed {
        logic accept;
        logic exec;
        logic drain;
        logic rd_capture;
        logic out_load;
    } t_ctl_cmd;

    typedef struct packed {
        logic go_read;
        logic more_blanks;
    } t_dp_status;

    typedef struct packed {
        logic       we;
        logic       index;
        logic [3:0] value;
    } t_cfg_wr;

endpackage

### rtl/fen_board_loader.sv
// ----------------------------------------------------------------------------
// fen_board_loader: board store loaded from FEN piece placement
// Top level: APB register decode, sequencer and datapath.
// ----------------------------------------------------------------------------
// The input channel carries one request per transfer: begin a load, one
// notation byte, or a read of one cell. Every request yields exactly one
// result transfer on the output channel with a status and a cell value.
// Two registers sit on the APB port: rank_count at 0x0, column_count at 0x4.
// Writing a value that differs from the held one clears the board and
// aborts any load in progress; pready is always high.
//
// A cell read goes through a registered memory read. A digit byte, or a rank
// separator that leaves n further blanks to write (n is at most 8), drains
// them before its result, since the datapath writes one cell per cycle
// through a single memory write port. The block takes a new request in the
// cycle after the previous result moves into the output register, and takes
// none while one is at work. A format error clears the board by dropping
// the per-cell valid bits.
//
// Reset clears the board to spaces, ends any load and sets both registers
// to 8. When the receiver stalls, the result waits in the output register
// and the next request is still taken and worked on; it only waits at the
// end until the output register is free.
// ----------------------------------------------------------------------------
module fen_board_loader import fbl_pkg::*; #(
    parameter int MAX_RANKS   = 8,
    parameter int MAX_COLUMNS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg_wr    cfg_wr;
    t_ctl_cmd   cmd;
    t_dp_status status;
    logic [3:0] rank_count;
    logic [3:0] column_count;

    // Registers are decoded on address bit 2 only; the low bits are ignored.
    assign pready       = 1'b1;
    assign cfg_wr.we    = psel && penable && pwrite;
    assign cfg_wr.index = paddr[2];
    assign cfg_wr.value = pwdata[3:0];
    assign prdata = {28'd0, (paddr[2] == CFG_COLUMN_COUNT) ? column_count : rank_count};

    fbl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid)
    );

    fbl_datapath #(
        .MAX_RANKS   (MAX_RANKS),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr       (cfg_wr),
        .i_cmd          (cmd),
        .i_in_item      (i_in_item),
        .o_status       (status),
        .o_out_item     (o_out_item),
        .o_rank_count   (rank_count),
        .o_column_count (column_count)
    );

endmodule

### rtl/fbl_datapath.sv
// ----------------------------------------------------------------------------
// fbl_datapath: board store, load cursor and result registers
// Holds the configuration, the cell memory with its valid bits, the load
// cursor and blank run, and the result and output registers.
// ----------------------------------------------------------------------------
module fbl_datapath import fbl_pkg::*; #(
    parameter int MAX_RANKS   = 8,
    parameter int MAX_COLUMNS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg_wr    i_cfg_wr,
    input  t_ctl_cmd   i_cmd,
    input  t_in_item   i_in_item,
    output t_dp_status o_status,
    output t_out_item  o_out_item,
    output logic [3:0] o_rank_count,
    output logic [3:0] o_column_count
);

    localparam int CELL_COUNT = MAX_RANKS * MAX_COLUMNS;
    localparam int AW = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
    localparam int RW = $clog2(MAX_RANKS + 1);
    localparam int CW = $clog2(MAX_COLUMNS + 2);

    logic [3:0]            r_rank_count;
    logic [3:0]            r_column_count;
    t_phase                r_phase, n_phase;
    logic [RW-1:0]         r_crank, n_crank;
    logic [CW-1:0]         r_ccol, n_ccol;
    logic [3:0]            r_run, n_run;
    t_in_item              r_item;
    logic [1:0]            r_res_status, n_res_status;
    logic [7:0]            r_res_cell;
    t_out_item             r_out;
    logic [7:0]            r_cells [CELL_COUNT];
    logic [CELL_COUNT-1:0] r_cell_valid;
    logic [7:0]            r_rd_data;
    logic                  r_rd_valid;

    logic [CMP_W-1:0] ranks_w;
    logic [CMP_W-1:0] cols_w;
    logic [RW-1:0]    eff_ranks;
    logic [CW-1:0]    eff_cols;
    logic             is_digit;
    logic             is_sep;
    logic [3:0]       digit;
    logic [CW-1:0]    col_inc;
    logic             past_end;
    logic             read_ok;
    logic [RW-1:0]    rank_m1;
    logic [CW-1:0]    col_m1;
    logic [AW-1:0]    wr_addr;
    logic [AW-1:0]    rd_addr;
    logic             wr_en;
    logic [7:0]       wr_data;
    logic             fmt_clear;
    logic             cfg_change;
    logic             clear_all;

    // Out-of-range register values act as saturated to 1..MAX.
    always_comb begin
        priority if (r_rank_count == 4'd0) begin
            ranks_w = CMP_W'(1);
        end else if (CMP_W'(r_rank_count) > CMP_W'(MAX_RANKS)) begin
            ranks_w = CMP_W'(MAX_RANKS);
        end else begin
            ranks_w = CMP_W'(r_rank_count);
        end
        priority if (r_column_count == 4'd0) begin
            cols_w = CMP_W'(1);
        end else if (CMP_W'(r_column_count) > CMP_W'(MAX_COLUMNS)) begin
            cols_w = CMP_W'(MAX_COLUMNS);
        end else begin
            cols_w = CMP_W'(r_column_count);
        end
    end

    assign eff_ranks = RW'(ranks_w);
    assign eff_cols  = CW'(cols_w);

    assign is_digit = (r_item.fen_byte >= CH_ZERO) && (r_item.fen_byte <= CH_NINE);
    assign is_sep   = (r_item.fen_byte == CH_SLASH) || (r_item.fen_byte == CH_BLANK);
    assign digit    = r_item.fen_byte[3:0];
    assign col_inc  = r_ccol + CW'(1);
    assign past_end = CMP_W'(col_inc) > cols_w;

    assign read_ok = (r_item.kind == KIND_READ)
                     && (r_item.read_column != 4'd0)
                     && (CMP_W'(r_item.read_column) <= cols_w)
                     && (r_item.read_rank != 4'd0)
                     && (CMP_W'(r_item.read_rank) <= ranks_w);

    // Cell (c, r) lives at (r-1)*columns + (c-1); the sum always stays
    // below the cell count, so modulo-2^AW arithmetic is exact.
    assign rank_m1 = r_crank - RW'(1);
    assign col_m1  = r_ccol - CW'(1);
    assign wr_addr = AW'(AW'(rank_m1) * AW'(eff_cols)) + AW'(col_m1);
    assign rd_addr = AW'(AW'(r_item.read_rank - 4'd1) * AW'(eff_cols))
                     + AW'(r_item.read_column - 4'd1);

    always_comb begin
        n_phase      = r_phase;
        n_crank      = r_crank;
        n_ccol       = r_ccol;
        n_run        = r_run;
        n_res_status = r_res_status;
        wr_en        = 1'b0;
        wr_data      = CH_BLANK;
        fmt_clear    = 1'b0;
        if (i_cmd.exec) begin
            n_res_status = STAT_BAD_REQ;
            unique case (r_item.kind)
                KIND_BEGIN: begin
                    n_phase      = PH_FILL;
                    n_crank      = eff_ranks;
                    n_ccol       = CW'(1);
                    n_run        = 4'd0;
                    n_res_status = STAT_OK;
                end
                KIND_BYTE: begin
                    unique case (r_phase)
                        PH_FILL: begin
                            wr_en        = 1'b1;
                            wr_data      = is_digit ? CH_BLANK : r_item.fen_byte;
                            n_ccol       = col_inc;
                            n_res_status = STAT_OK;
                            if (past_end) begin
                                n_phase = PH_SEP;
                            end
                            if (is_digit) begin
                                n_run = (digit != 4'd0) ? digit - 4'd1 : 4'd0;
                            end
                        end
                        PH_SEP: begin
                            if (is_sep && (r_crank <= RW'(1))) begin
                                // Last rank closed: the load ends and any
                                // pending blanks are dropped.
                                n_phase      = PH_IDLE;
                                n_crank      = '0;
                                n_ccol       = '0;
                                n_run        = 4'd0;
                                n_res_status = STAT_LOADED;
                            end else if (is_sep) begin
                                n_phase      = PH_FILL;
                                n_crank      = r_crank - RW'(1);
                                n_ccol       = CW'(1);
                                n_res_status = STAT_OK;
                            end else begin
                                fmt_clear    = 1'b1;
                                n_phase      = PH_IDLE;
                                n_crank      = '0;
                                n_ccol       = '0;
                                n_run        = 4'd0;
                                n_res_status = STAT_FORMAT_ERR;
                            end
                        end
                        default: begin
                            n_res_status = STAT_BAD_REQ;
                        end
                    endcase
                end
                KIND_READ: begin
                    n_res_status = read_ok ? STAT_OK : STAT_BAD_REQ;
                end
                default: begin
                    n_res_status = STAT_BAD_REQ;
                end
            endcase
        end else if (i_cmd.drain) begin
            wr_en  = 1'b1;
            n_ccol = col_inc;
            n_run  = r_run - 4'd1;
            if (past_end) begin
                n_phase = PH_SEP;
            end
        end
    end

    assign o_status.go_read     = read_ok;
    assign o_status.more_blanks = (n_run != 4'd0) && (n_phase == PH_FILL);

    assign cfg_change = i_cfg_wr.we
        && (((i_cfg_wr.index == CFG_RANK_COUNT) && (i_cfg_wr.value != r_rank_count))
         || ((i_cfg_wr.index == CFG_COLUMN_COUNT) && (i_cfg_wr.value != r_column_count)));
    assign clear_all = cfg_change || fmt_clear;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank_count   <= RANK_COUNT_RESET;
            r_column_count <= COLUMN_COUNT_RESET;
        end else if (i_cfg_wr.we) begin
            if (i_cfg_wr.index == CFG_RANK_COUNT) begin
                r_rank_count <= i_cfg_wr.value;
            end else begin
                r_column_count <= i_cfg_wr.value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_crank <= '0;
            r_ccol  <= '0;
            r_run   <= 4'd0;
        end else if (cfg_change) begin
            r_phase <= PH_IDLE;
            r_crank <= '0;
            r_ccol  <= '0;
            r_run   <= 4'd0;
        end else begin
            r_phase <= n_phase;
            r_crank <= n_crank;
            r_ccol  <= n_ccol;
            r_run   <= n_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_item <= i_in_item;
        end
        r_res_status <= n_res_status;
        if (i_cmd.exec) begin
            r_res_cell <= 8'h00;
        end else if (i_cmd.rd_capture) begin
            r_res_cell <= r_rd_valid ? r_rd_data : CH_BLANK;
        end
        if (i_cmd.out_load) begin
            r_out.status     <= r_res_status;
            r_out.cell_value <= r_res_cell;
        end
    end

    // A cell that has not been written since the last clear reads as blank.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_valid <= '0;
        end else if (clear_all) begin
            r_cell_valid <= '0;
        end else if (wr_en) begin
            r_cell_valid[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_cells[wr_addr] <= wr_data;
        end
        r_rd_data  <= r_cells[rd_addr];
        r_rd_valid <= r_cell_valid[rd_addr];
    end

    assign o_out_item     = r_out;
    assign o_rank_count   = r_rank_count;
    assign o_column_count = r_column_count;

endmodule

### rtl/fbl_ctrl.sv
// ----------------------------------------------------------------------------
// fbl_ctrl: sequencer of the board loader
// Steps each request through execute, blank drain or cell read, and hands
// the result to the output register when it is free.
// ----------------------------------------------------------------------------
module fbl_ctrl import fbl_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_ctl_cmd   o_cmd,
    output logic       o_in_ready,
    output logic       o_out_valid
);

    t_ctl_state r_state, n_state;
    logic       r_out_valid;
    logic       out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            CS_IDLE: begin
                if (i_in_valid) begin
                    n_state = CS_EXEC;
                end
            end
            CS_EXEC: begin
                priority if (i_status.go_read) begin
                    n_state = CS_READ;
                end else if (i_status.more_blanks) begin
                    n_state = CS_DRAIN;
                end else begin
                    n_state = CS_DONE;
                end
            end
            CS_DRAIN: begin
                n_state = i_status.more_blanks ? CS_DRAIN : CS_DONE;
            end
            CS_READ: begin
                n_state = CS_DONE;
            end
            CS_DONE: begin
                if (out_free) begin
                    n_state = CS_IDLE;
                end
            end
            default: begin
                n_state = CS_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready       = (r_state == CS_IDLE);
        o_cmd.accept     = (r_state == CS_IDLE) && i_in_valid;
        o_cmd.exec       = (r_state == CS_EXEC);
        o_cmd.drain      = (r_state == CS_DRAIN);
        o_cmd.rd_capture = (r_state == CS_READ);
        o_cmd.out_load   = (r_state == CS_DONE) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= CS_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

### rtl/fbl_checker.sv
// ----------------------------------------------------------------------------
// fbl_checker: port-level checks of the board loader
// Watches the top-level ports and is bound to every instance of the block.
// ----------------------------------------------------------------------------
module fbl_checker import fbl_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input t_out_item   o_out_item
);

    a_out_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("result withdrawn before its transfer");

    a_out_item_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> $stable(o_out_item))
        else $error("stalled result changed");

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_in_ready && !o_out_valid))
        else $error("block not idle after reset");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request taken while another is at work");

    a_cell_only_on_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.status != STAT_OK)) |-> (o_out_item.cell_value == 8'h00))
        else $error("cell value set on a result that is not an accepted read");

endmodule

bind fen_board_loader fbl_checker u_fbl_checker (.*);
